// ----- rtl/imt_pkg.sv -----
// ----------------------------------------------------------------------------
// IRC message tokenizer package
// Shared types and character constants for the tokenizer and its checker.
// ----------------------------------------------------------------------------
package imt_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [1:0] KIND_PREFIX   = 2'd0;
    localparam logic [1:0] KIND_COMMAND  = 2'd1;
    localparam logic [1:0] KIND_PARAM    = 2'd2;
    localparam logic [1:0] KIND_TRAILING = 2'd3;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = PTR_W + 1;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_HEAD  = 2'd1,
        PH_TRAIL = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] token_kind;
        logic       token_start;
        logic       byte_valid;
        logic       message_end;
        logic       trailing_present;
    } t_out;

endpackage

// ----- rtl/irc_message_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// IRC message tokenizer
// Each result is written into the output queue registers and read out from its head.
// Throughput: one byte per cycle while input ready is high; the last byte of a
// message also issues an end-of-message result, absorbed by a 4-entry queue.
// Input ready is high while at least two queue slots are free.
// Synchronous active-low reset empties the queue and returns to message start.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_top
    import imt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_phase     r_phase, n_phase;
    logic       r_inside, n_inside;
    logic [1:0] r_role, n_role;
    logic       r_prefix, n_prefix;
    logic       r_colon, n_colon;
    logic       r_trail_st, n_trail_st;

    t_out             r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic       in_fire, out_fire;
    logic       is_colon, is_space, is_comma, in_head;
    logic       emit;
    t_out       byte_res, end_res, ent0, ent1;
    logic [1:0] push;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;
    assign is_colon = (i_in_data.msg_byte == CH_COLON);
    assign is_space = (i_in_data.msg_byte == CH_SPACE);
    assign is_comma = (i_in_data.msg_byte == CH_COMMA);

    always_comb begin
        n_phase    = r_phase;
        n_inside   = r_inside;
        n_role     = r_role;
        n_prefix   = r_prefix;
        n_colon    = r_colon;
        n_trail_st = r_trail_st;
        emit       = 1'b0;
        in_head    = 1'b0;
        byte_res   = '0;
        byte_res.out_byte   = i_in_data.msg_byte;
        byte_res.byte_valid = 1'b1;

        unique case (r_phase)
            PH_LEAD: begin
                if (is_colon) begin
                    n_prefix = 1'b1;
                    n_colon  = 1'b1;
                end else begin
                    n_phase  = PH_HEAD;
                    n_role   = r_prefix ? KIND_PREFIX : KIND_COMMAND;
                    n_inside = 1'b0;
                    in_head  = 1'b1;
                end
            end
            PH_HEAD: begin
                if (is_colon) begin
                    if (r_inside) begin
                        n_inside = 1'b0;
                        if (r_role != KIND_PARAM) begin
                            n_role = r_role + 2'd1;
                        end
                    end
                    n_colon = 1'b1;
                    n_phase = PH_TRAIL;
                end else begin
                    in_head = 1'b1;
                end
            end
            default: begin
                if (is_colon) begin
                    n_colon = 1'b1;
                end else begin
                    emit                 = 1'b1;
                    byte_res.token_kind  = KIND_TRAILING;
                    byte_res.token_start = !r_trail_st;
                    n_trail_st           = 1'b1;
                end
            end
        endcase

        if (in_head) begin
            if (is_space) begin
                if (n_inside) begin
                    if (n_role != KIND_PARAM) begin
                        n_role = n_role + 2'd1;
                    end
                end
                n_inside = 1'b0;
            end else if (is_comma && (n_role == KIND_PARAM)) begin
                n_inside = 1'b0;
            end else begin
                emit                 = 1'b1;
                byte_res.token_kind  = n_role;
                byte_res.token_start = !n_inside;
                n_inside             = 1'b1;
            end
        end

        end_res = '0;
        end_res.message_end      = 1'b1;
        end_res.trailing_present = n_colon;

        if (i_in_data.last_byte) begin
            n_phase    = PH_LEAD;
            n_inside   = 1'b0;
            n_role     = KIND_PREFIX;
            n_prefix   = 1'b0;
            n_colon    = 1'b0;
            n_trail_st = 1'b0;
        end

        ent0 = emit ? byte_res : end_res;
        ent1 = end_res;
        push = in_fire ? ({1'b0, emit} + {1'b0, i_in_data.last_byte}) : 2'd0;
        n_count = r_count + CNT_W'(push) - CNT_W'(out_fire);
    end

    assign o_in_ready  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEAD;
            r_inside   <= 1'b0;
            r_role     <= KIND_PREFIX;
            r_prefix   <= 1'b0;
            r_colon    <= 1'b0;
            r_trail_st <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (in_fire) begin
                r_phase    <= n_phase;
                r_inside   <= n_inside;
                r_role     <= n_role;
                r_prefix   <= n_prefix;
                r_colon    <= n_colon;
                r_trail_st <= n_trail_st;
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(push);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_fifo[r_wr_ptr] <= ent0;
        end
        if (push == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= ent1;
        end
    end

endmodule

// ----- rtl/imt_checker.sv -----
// ----------------------------------------------------------------------------
// IRC message tokenizer checker
// Port-level assertions on the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module imt_checker
    import imt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    a_byte_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_valid |->
            !o_out_data.message_end && !o_out_data.trailing_present)
        else $error("byte result carries end flags");

    a_end_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |->
            o_out_data.message_end && (o_out_data.out_byte == 8'd0) &&
            (o_out_data.token_kind == KIND_PREFIX) && !o_out_data.token_start)
        else $error("malformed end result");

endmodule

bind irc_message_tokenizer_top imt_checker u_imt_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRC message tokenizer testbench
// Streams directed and random messages into the tokenizer one byte per
// transaction. A behavioural tokeniser predicts the tagged token bytes and
// end-of-message results, which are checked in order as they are accepted.
// Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import imt_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    irc_message_tokenizer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    t_in         byte_feed[$];
    logic [7:0]  msg_buf[$];
    t_out        token_q[$];
    int unsigned feed_total = 0;
    int unsigned sent_cnt   = 0;
    int unsigned fail_cnt   = 0;

    // tokeniser state
    t_phase     ph          = PH_LEAD;
    logic       tok_open    = 1'b0;
    logic [1:0] head_kind   = KIND_PREFIX;
    logic       lead_colon  = 1'b0;
    logic       colon_hit   = 1'b0;
    logic       trail_begun = 1'b0;

    function automatic void close_token();
        if (tok_open) begin
            tok_open = 1'b0;
            if (head_kind < KIND_PARAM)
                head_kind = head_kind + 2'd1;
        end
    endfunction

    function automatic void tokenise(input t_in t);
        logic [7:0] c;
        t_out       r;
        c = t.msg_byte;
        case (ph)
            PH_LEAD: begin
                if (c == CH_COLON) begin
                    lead_colon = 1'b1;
                    colon_hit  = 1'b1;
                end else begin
                    ph        = PH_HEAD;
                    head_kind = lead_colon ? KIND_PREFIX : KIND_COMMAND;
                    tok_open  = 1'b0;
                end
            end
            PH_HEAD: begin
                if (c == CH_COLON) begin
                    close_token();
                    colon_hit = 1'b1;
                    ph        = PH_TRAIL;
                end
            end
            default: begin
                if (c == CH_COLON) begin
                    colon_hit = 1'b1;
                end else begin
                    r = '{c, KIND_TRAILING, !trail_begun, 1'b1, 1'b0, 1'b0};
                    token_q.insert(token_q.size(), r);
                    trail_begun = 1'b1;
                end
            end
        endcase
        if (ph == PH_HEAD && c != CH_COLON) begin
            if (c == CH_SPACE) begin
                close_token();
            end else if (c == CH_COMMA && head_kind == KIND_PARAM) begin
                tok_open = 1'b0;
            end else begin
                r = '{c, head_kind, !tok_open, 1'b1, 1'b0, 1'b0};
                token_q.insert(token_q.size(), r);
                tok_open = 1'b1;
            end
        end
        if (t.last_byte) begin
            r = '{8'h00, KIND_PREFIX, 1'b0, 1'b0, 1'b1, colon_hit};
            token_q.insert(token_q.size(), r);
            ph          = PH_LEAD;
            tok_open    = 1'b0;
            head_kind   = KIND_PREFIX;
            lead_colon  = 1'b0;
            colon_hit   = 1'b0;
            trail_begun = 1'b0;
        end
    endfunction

    function automatic void check_result(input t_out got);
        t_out want;
        logic bad;
        if (token_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("unexpected transaction: %h", got);
            return;
        end
        want = token_q.pop_front();
        bad  = (got.out_byte !== want.out_byte) ||
               (got.token_kind !== want.token_kind) ||
               (got.token_start !== want.token_start) ||
               (got.byte_valid !== want.byte_valid) ||
               (got.message_end !== want.message_end) ||
               (got.trailing_present !== want.trailing_present);
        if (bad) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
                $display("mismatch: exp byte=%h kind=%0d start=%b valid=%b end=%b tp=%b",
                         want.out_byte, want.token_kind, want.token_start,
                         want.byte_valid, want.message_end, want.trailing_present);
                $display("          got byte=%h kind=%0d start=%b valid=%b end=%b tp=%b",
                         got.out_byte, got.token_kind, got.token_start,
                         got.byte_valid, got.message_end, got.trailing_present);
            end
        end
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // driver
    int unsigned in_gap  = 0;
    int unsigned in_calm = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
            in_calm  <= 0;
        end else begin
            if (in_valid && in_ready) begin
                tokenise(in_data);
                sent_cnt++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap != 0) begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end else if (byte_feed.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= byte_feed.pop_front();
                    if (in_calm != 0) begin
                        in_calm <= in_calm - 1;
                        in_gap  <= 0;
                    end else begin
                        in_gap <= idle_len();
                        if ($urandom_range(0, 49) == 0)
                            in_calm <= $urandom_range(20, 120);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int unsigned out_stall = 0;
    int unsigned out_calm  = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
            out_calm  <= 0;
        end else begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (out_stall != 0) begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end else begin
                out_ready <= 1'b1;
                if (out_calm != 0) begin
                    out_calm <= out_calm - 1;
                end else begin
                    out_stall <= idle_len();
                    if ($urandom_range(0, 49) == 0)
                        out_calm <= $urandom_range(20, 120);
                end
            end
        end
    end

    function automatic void add_char(input logic [7:0] ch);
        msg_buf.insert(msg_buf.size(), ch);
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic flush_msg();
        t_in t;
        foreach (msg_buf[i]) begin
            t.msg_byte  = msg_buf[i];
            t.last_byte = (i == msg_buf.size() - 1);
            byte_feed.insert(byte_feed.size(), t);
        end
        msg_buf.delete();
    endtask

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 4))
            0:       return CH_COLON;
            1:       return CH_SPACE;
            2:       return CH_COMMA;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_word();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 9) == 0)
                add_char(8'($urandom_range(0, 255)));
            else
                add_char(8'($urandom_range(8'h41, 8'h7A)));
        end
    endtask

    task automatic gen_message();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 12))
                add_char(noise_char());
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 3))
                    add_char(CH_COLON);
                add_word();
                add_char(CH_SPACE);
            end
            if ($urandom_range(0, 5) == 0)
                add_char(CH_SPACE);
            add_word();
            repeat ($urandom_range(0, 3)) begin
                repeat ($urandom_range(1, 2))
                    add_char(CH_SPACE);
                add_word();
                repeat ($urandom_range(0, 2)) begin
                    repeat ($urandom_range(1, 2))
                        add_char(CH_COMMA);
                    add_word();
                end
            end
            if ($urandom_range(0, 9) < 6) begin
                add_char(CH_SPACE);
                add_char(CH_COLON);
                repeat ($urandom_range(0, 8))
                    add_char(noise_char());
            end
        end
        flush_msg();
    endtask

    initial begin
        // colons only, spaces-only head, single-byte extremes,
        // every token kind, prefix only
        add_text(":::");
        flush_msg();
        add_text("  :");
        flush_msg();
        add_char(8'hFF);
        flush_msg();
        add_char(8'h00);
        flush_msg();
        add_text(":p c a,,b :t: ,");
        flush_msg();
        add_text(":p");
        flush_msg();
        while (byte_feed.size() < 1650)
            gen_message();
        feed_total = byte_feed.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt != feed_total)
            @(posedge clk);
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && token_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ----- irc_message_tokenizer_top.f -----
rtl/imt_pkg.sv
rtl/irc_message_tokenizer_top.sv
rtl/imt_checker.sv
tb/sv/tb_top.sv
